// ----- hw/rtl/jac_pkg.sv -----
// Shared constants, payload types and control structs of the joystick axis conditioner.
`default_nettype none

package jac_pkg;

	localparam int SAMPLE_BITS = 12;
	localparam int CAL_SAMPLES = 64;
	localparam int NUM_AXES    = 2;

	localparam int CFG_BITS   = 12;
	localparam int POS_W      = 8;
	localparam int POS_FRAC   = 7;
	localparam int FULL_OUT   = 127;
	localparam int FILT_SHIFT = 3;

	localparam int AXIS_W  = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
	localparam int CAL_LOG = $clog2(CAL_SAMPLES);
	localparam int CNT_W   = (CAL_LOG > 0) ? CAL_LOG : 1;
	localparam int SUM_W   = SAMPLE_BITS + CAL_LOG;
	localparam int F_W     = SAMPLE_BITS + 1;
	localparam int ACC_W   = SAMPLE_BITS + FILT_SHIFT + 1;
	localparam int PROD_W  = SAMPLE_BITS + POS_FRAC;
	localparam int CALN_W  = $clog2(CAL_SAMPLES + 1);
	localparam int DVS_W   = (CFG_BITS > CALN_W) ? CFG_BITS : CALN_W;
	localparam int LO_W    = SAMPLE_BITS;
	localparam int ITER_W  = $clog2(LO_W + 1);

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_DEADZONE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SPAN     = CFG_IDX_W'(1);

	localparam logic [CFG_BITS-1:0] DEADZONE_RST   = CFG_BITS'(170);
	localparam logic [CFG_BITS-1:0] SPAN_RST       = CFG_BITS'(1450);
	localparam logic [SAMPLE_BITS-1:0] CENTER_RST  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	typedef struct packed {
		logic                   kind;
		logic [AXIS_W-1:0]      axis_select;
		logic [SAMPLE_BITS-1:0] sample;
	} item_t;

	typedef struct packed {
		logic [AXIS_W-1:0]       axis_out;
		logic signed [POS_W-1:0] position;
	} result_t;

	typedef struct packed {
		logic              start;
		logic [DVS_W-1:0]  rem;
		logic [LO_W-1:0]   low;
		logic [DVS_W-1:0]  divisor;
		logic [ITER_W-1:0] iters;
	} div_req_t;

	typedef struct packed {
		logic            busy;
		logic            done;
		logic [LO_W-1:0] quot;
	} div_rsp_t;

	typedef struct packed {
		logic [AXIS_W-1:0]      axis;
		logic                   filter_we;
		logic signed [F_W-1:0]  filter;
		logic                   cal_we;
		logic [SUM_W-1:0]       sum;
		logic [CNT_W-1:0]       count;
		logic                   center_we;
		logic [SAMPLE_BITS-1:0] center;
	} bank_wr_t;

endpackage

`default_nettype wire

// ----- hw/rtl/jac_serial_div.sv -----
// Restoring divider that retires one quotient bit per cycle.
`default_nettype none

module jac_serial_div (
	input  logic               clk,
	input  logic               arst_n,
	input  jac_pkg::div_req_t  req,
	output jac_pkg::div_rsp_t  rsp
);
	import jac_pkg::*;

	logic              busy_q;
	logic [ITER_W-1:0] cnt_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [LO_W-1:0]   low_q;
	logic [LO_W-1:0]   quot_q;

	logic [DVS_W:0]   trial;
	logic             fits;
	logic [DVS_W-1:0] rem_next;

	// Shift the next dividend bit into the remainder and try the subtract.
	assign trial    = {rem_q, low_q[LO_W-1]} - {1'b0, dvs_q};
	assign fits     = !trial[DVS_W];
	assign rem_next = fits ? trial[DVS_W-1:0] : {rem_q[DVS_W-2:0], low_q[LO_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= req.iters;
			rem_q  <= req.rem;
			dvs_q  <= req.divisor;
			low_q  <= req.low;
			quot_q <= '0;
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				cnt_q  <= cnt_q - 1'b1;
				rem_q  <= rem_next;
				low_q  <= {low_q[LO_W-2:0], 1'b0};
				quot_q <= {quot_q[LO_W-2:0], fits};
			end else begin
				busy_q <= 1'b0;
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = busy_q && (cnt_q == '0);
	assign rsp.quot = quot_q;

endmodule

`default_nettype wire

// ----- hw/rtl/jac_axis_bank.sv -----
// Per-axis state: center, filter value and calibration sum and count.
`default_nettype none

module jac_axis_bank (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [jac_pkg::AXIS_W-1:0]           rd_axis,
	input  jac_pkg::bank_wr_t                    wr,
	output logic [jac_pkg::SAMPLE_BITS-1:0]      center,
	output logic signed [jac_pkg::F_W-1:0]       filter,
	output logic [jac_pkg::SUM_W-1:0]            cal_sum,
	output logic [jac_pkg::CNT_W-1:0]            cal_count
);
	import jac_pkg::*;

	logic [SAMPLE_BITS-1:0] center_q [NUM_AXES];
	logic signed [F_W-1:0]  filter_q [NUM_AXES];
	logic [SUM_W-1:0]       sum_q    [NUM_AXES];
	logic [CNT_W-1:0]       cnt_q    [NUM_AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				center_q[i] <= CENTER_RST;
				filter_q[i] <= '0;
				sum_q[i]    <= '0;
				cnt_q[i]    <= '0;
			end
		end else begin
			if (wr.center_we) begin
				center_q[wr.axis] <= wr.center;
			end
			if (wr.filter_we) begin
				filter_q[wr.axis] <= wr.filter;
			end
			if (wr.cal_we) begin
				sum_q[wr.axis] <= wr.sum;
				cnt_q[wr.axis] <= wr.count;
			end
		end
	end

	assign center    = center_q[rd_axis];
	assign filter    = filter_q[rd_axis];
	assign cal_sum   = sum_q[rd_axis];
	assign cal_count = cnt_q[rd_axis];

endmodule

`default_nettype wire

// ----- hw/rtl/joystick_axis_conditioner.sv -----
// Top level of the joystick axis conditioner: control sequencer, mapping and result register.
// Tracking sample: S_DELTA, S_FILT and S_MAP lead to S_DONE when the filtered value lands in
//   the deadzone or saturates, otherwise S_MAP_DIV comes between, set by the POS_FRAC-step
//   quotient loop of the divider; the next item may enter when the output register is free.
// Calibration sample: S_CAL returns to idle for the next item; the sample that closes a
//   calibration run also passes S_CAL_DIV, which waits on the SAMPLE_BITS-step divide of the sum.
// One item in flight at a time; a finished result may wait in the output register meanwhile.
// Reset: centers at midscale, filters, sums and counts cleared, deadzone 170, full scale 1450.
`default_nettype none

module joystick_axis_conditioner (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  jac_pkg::item_t                    item,
	output logic                              result_valid,
	input  logic                              result_stall,
	output jac_pkg::result_t                  result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [jac_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [jac_pkg::CFG_BITS-1:0]      cfg_data
);
	import jac_pkg::*;

	localparam int MX_W  = (SAMPLE_BITS > CFG_BITS) ? SAMPLE_BITS : CFG_BITS;
	localparam int CMP_W = (PROD_W > DVS_W + POS_FRAC) ? PROD_W : DVS_W + POS_FRAC;
	localparam logic signed [POS_W-1:0] POS_MAX = POS_W'(FULL_OUT);
	localparam logic signed [POS_W-1:0] POS_MIN = -POS_W'(FULL_OUT);
	localparam logic signed [ACC_W-1:0] TRUNC_ADJ = ACC_W'((1 << FILT_SHIFT) - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CAL,
		S_CAL_DIV,
		S_DELTA,
		S_FILT,
		S_MAP,
		S_MAP_DIV,
		S_DONE
	} state_t;

	state_t                  state_q;
	logic [AXIS_W-1:0]       axis_q;
	logic [SAMPLE_BITS-1:0]  smp_q;
	logic signed [F_W-1:0]   delta_q;
	logic signed [ACC_W-1:0] f7_q;
	logic signed [F_W-1:0]   f_q;
	logic                    neg_q;
	logic signed [POS_W-1:0] pos_q;
	result_t                 res_q;
	logic                    res_valid_q;
	logic [CFG_BITS-1:0]     deadzone_q;
	logic [CFG_BITS-1:0]     span_q;

	// Axis state bank and shared divider
	logic [SAMPLE_BITS-1:0] center_rd;
	logic signed [F_W-1:0]  filter_rd;
	logic [SUM_W-1:0]       sum_rd;
	logic [CNT_W-1:0]       cnt_rd;
	bank_wr_t               bank_wr;
	div_req_t               div_req;
	div_rsp_t               div_rsp;

	jac_axis_bank u_bank (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_axis   (axis_q),
		.wr        (bank_wr),
		.center    (center_rd),
		.filter    (filter_rd),
		.cal_sum   (sum_rd),
		.cal_count (cnt_rd)
	);

	jac_serial_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Configuration: always ready; write only while the block is idle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadzone_q <= DEADZONE_RST;
			span_q     <= SPAN_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DEADZONE: deadzone_q <= cfg_data;
				REG_SPAN:     span_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Handshake: take an item only when the sequencer is idle.
	logic item_take;
	logic axis_ok;
	logic res_free;

	assign item_stall = (state_q != S_IDLE);
	assign item_take  = item_valid && (state_q == S_IDLE);
	assign axis_ok    = ({1'b0, item.axis_select} < (AXIS_W + 1)'(NUM_AXES));
	assign res_free   = !res_valid_q || !result_stall;

	// Filter datapath: delta and 7*f first, then the add and the divide by 8 toward zero.
	logic signed [F_W-1:0]   delta;
	logic signed [ACC_W-1:0] f_ext;
	logic signed [ACC_W-1:0] f7;
	logic signed [ACC_W-1:0] acc;
	logic signed [ACC_W-1:0] acc_adj;
	logic signed [F_W-1:0]   f_new;

	assign delta   = $signed({1'b0, smp_q}) - $signed({1'b0, center_rd});
	assign f_ext   = ACC_W'(filter_rd);
	assign f7      = (f_ext <<< FILT_SHIFT) - f_ext;
	assign acc     = f7_q + ACC_W'(delta_q);
	// Negative sums get a bias so the arithmetic shift truncates toward zero.
	assign acc_adj = acc + (acc[ACC_W-1] ? TRUNC_ADJ : '0);
	assign f_new   = F_W'(acc_adj >>> FILT_SHIFT);

	// Mapping: magnitude, deadzone test, f*127 and the saturation test against scale*128.
	logic signed [F_W-1:0]   f_abs;
	logic [SAMPLE_BITS-1:0]  mag;
	logic                    in_dead;
	logic [PROD_W-1:0]       prod;
	logic [DVS_W-1:0]        scale_eff;
	logic                    sat;
	logic signed [POS_W-1:0] q_pos;

	assign f_abs     = f_q[F_W-1] ? -f_q : f_q;
	assign mag       = f_abs[SAMPLE_BITS-1:0];
	assign in_dead   = MX_W'(mag) < MX_W'(deadzone_q);
	assign prod      = (PROD_W'(mag) << POS_FRAC) - PROD_W'(mag);
	// A full scale of zero behaves as one: anything outside the deadzone saturates.
	assign scale_eff = (span_q == '0) ? DVS_W'(1) : DVS_W'(span_q);
	assign sat       = CMP_W'(prod) >= (CMP_W'(scale_eff) << POS_FRAC);
	assign q_pos     = $signed(POS_W'(div_rsp.quot[POS_FRAC-1:0]));

	// Calibration accumulate
	logic [SUM_W-1:0] sum_new;
	logic             cal_last;

	assign sum_new  = sum_rd + SUM_W'(smp_q);
	assign cal_last = (cnt_rd == CNT_W'(CAL_SAMPLES - 1));

	// Divider launch. The remainder starts with the dividend's high part, which is known to
	// be below the divisor, so only the quotient bits that matter are produced.
	always_comb begin
		div_req         = '0;
		div_req.divisor = scale_eff;
		if (state_q == S_CAL && cal_last) begin
			// center = sum / CAL_SAMPLES, SAMPLE_BITS quotient bits
			div_req.start   = 1'b1;
			div_req.rem     = DVS_W'(sum_new >> SAMPLE_BITS);
			div_req.low     = LO_W'(sum_new);
			div_req.divisor = DVS_W'(CAL_SAMPLES);
			div_req.iters   = ITER_W'(SAMPLE_BITS);
		end else if (state_q == S_MAP && !in_dead && !sat) begin
			// |f|*127 / full_scale, known below 128 here
			div_req.start = 1'b1;
			div_req.rem   = DVS_W'(prod >> POS_FRAC);
			div_req.low   = {prod[POS_FRAC-1:0], {(LO_W-POS_FRAC){1'b0}}};
			div_req.iters = ITER_W'(POS_FRAC);
		end
	end

	// Axis state updates
	always_comb begin
		bank_wr      = '0;
		bank_wr.axis = axis_q;
		case (state_q)
			S_CAL: begin
				// Accumulate; the closing sample restarts sum and count.
				bank_wr.cal_we = 1'b1;
				bank_wr.sum    = cal_last ? '0 : sum_new;
				bank_wr.count  = cal_last ? '0 : cnt_rd + 1'b1;
			end
			S_CAL_DIV: begin
				// Install the new center and drop the filter history.
				bank_wr.center_we = div_rsp.done;
				bank_wr.center    = div_rsp.quot[SAMPLE_BITS-1:0];
				bank_wr.filter_we = div_rsp.done;
			end
			S_FILT: begin
				bank_wr.filter_we = 1'b1;
				bank_wr.filter    = f_new;
			end
			default: ;
		endcase
	end

	// Sequencer with result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			// Release the output register once its beat is taken, unless a new result lands.
			if (res_valid_q && !result_stall && state_q != S_DONE) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (item_take) begin
						axis_q <= item.axis_select;
						smp_q  <= item.sample;
						// Drop samples for axes that do not exist.
						if (axis_ok) begin
							state_q <= item.kind ? S_CAL : S_DELTA;
						end
					end
				end
				S_CAL: begin
					state_q <= cal_last ? S_CAL_DIV : S_IDLE;
				end
				S_CAL_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_IDLE;
					end
				end
				S_DELTA: begin
					delta_q <= delta;
					f7_q    <= f7;
					state_q <= S_FILT;
				end
				S_FILT: begin
					f_q     <= f_new;
					state_q <= S_MAP;
				end
				S_MAP: begin
					neg_q <= f_q[F_W-1];
					if (in_dead) begin
						pos_q   <= '0;
						state_q <= S_DONE;
					end else if (sat) begin
						pos_q   <= f_q[F_W-1] ? POS_MIN : POS_MAX;
						state_q <= S_DONE;
					end else begin
						state_q <= S_MAP_DIV;
					end
				end
				S_MAP_DIV: begin
					if (div_rsp.done) begin
						pos_q   <= neg_q ? -q_pos : q_pos;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					// Hold until the output register frees up.
					if (res_free) begin
						res_q.axis_out <= axis_q;
						res_q.position <= pos_q;
						res_valid_q    <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	// A new result beat only ever comes from the completion state.
	a_res_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == S_DONE))
		else $error("result raised outside completion state");

	// Positions never fall below negative full output.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> ($signed(res_q.position) >= POS_MIN))
		else $error("position below negative full output");

	// The divider is never relaunched while it still works.
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	// Closing a calibration run leaves that axis's filter at zero.
	a_cal_clears_filter: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CAL_DIV && div_rsp.done) |=> (filter_rd == '0))
		else $error("filter not cleared after calibration");

endmodule

`default_nettype wire
